// File: rtl/wsd_pkg.sv
// wsd_pkg: shared types and constants for the work stealing deque core
// no dependencies; used by work_stealing_deque_core

package wsd_pkg;

    // fixed field widths of a beat and the default depth
    localparam int HANDLE_WIDTH  = 32;
    localparam int COUNT_WIDTH   = 7;
    localparam int DEPTH_DEFAULT = 64;

    // request codes
    localparam logic REQ_PUSH = 1'b0;
    localparam logic REQ_POP  = 1'b1;

    // end selection
    localparam logic END_HEAD = 1'b0;
    localparam logic END_TAIL = 1'b1;

    // request beat
    typedef struct packed {
        logic                    req_type;
        logic                    use_tail;
        logic [HANDLE_WIDTH-1:0] task_handle;
    } req_t;

    // result beat
    typedef struct packed {
        logic [HANDLE_WIDTH-1:0] popped_handle;
        logic                    popped_valid;
        logic                    push_rejected;
        logic                    queue_empty;
        logic [COUNT_WIDTH-1:0]  entry_count;
    } rsp_t;

endpackage

// File: rtl/work_stealing_deque_core.sv
// work_stealing_deque_core: bounded double-ended task queue for work stealing
// depends on wsd_pkg and wsd_store
//
// usage: drive req and raise start for one cycle per beat; a beat is taken at
// every rising edge with start high and busy low. busy is always low, so a
// push or a pop can be issued every cycle (one beat per cycle sustained).
// req_type selects push or pop, use_tail selects the tail end (ordinary push
// or steal) or the head end (new/revived push or owner pop).
// each request gives exactly one result beat: done is high for one cycle,
// the cycle right after the request edge, with rsp valid during that cycle.
// the result is registered; the handle comes from the registered read port of the task store.
// the receiver cannot stall; a result must be taken in its done cycle.
// a pop on an empty queue returns popped_valid low and a zero handle; a push
// on a full ring is dropped with push_rejected high. both leave state alone.
// reset (rst_n low, asynchronous) empties the queue and clears both indices;
// the storage itself is not cleared, as the count guards every read.

module work_stealing_deque_core #(
    parameter int DEPTH = wsd_pkg::DEPTH_DEFAULT
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    output logic          busy,
    input  wsd_pkg::req_t req,
    output logic          done,
    output wsd_pkg::rsp_t rsp
);

    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    logic [IDX_W-1:0] head_reg, head_next;
    logic [IDX_W-1:0] tail_reg, tail_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             done_reg;
    logic             valid_reg, valid_next;
    logic             reject_reg, reject_next;

    logic             accept;
    logic             is_pop;
    logic             at_tail;
    logic             wr_en;
    logic             rd_en;
    logic [IDX_W-1:0] wr_addr;
    logic [IDX_W-1:0] rd_addr;
    logic [IDX_W-1:0] head_inc, head_dec, tail_inc, tail_dec;
    logic [wsd_pkg::HANDLE_WIDTH-1:0] rd_data;
    logic [CNT_W+wsd_pkg::COUNT_WIDTH-1:0] count_ext;

    assign busy    = 1'b0;
    assign accept  = start && !busy;
    assign is_pop  = (req.req_type == wsd_pkg::REQ_POP);
    assign at_tail = (req.use_tail == wsd_pkg::END_TAIL);

    // ring index neighbors
    assign head_inc = (head_reg == LAST_IDX) ? '0 : head_reg + 1'b1;
    assign head_dec = (head_reg == '0) ? LAST_IDX : head_reg - 1'b1;
    assign tail_inc = (tail_reg == LAST_IDX) ? '0 : tail_reg + 1'b1;
    assign tail_dec = (tail_reg == '0) ? LAST_IDX : tail_reg - 1'b1;

    // next pointer, count, flags and storage access for one beat
    always_comb
    begin
        head_next   = head_reg;
        tail_next   = tail_reg;
        count_next  = count_reg;
        valid_next  = 1'b0;
        reject_next = 1'b0;
        wr_en       = 1'b0;
        rd_en       = 1'b0;
        wr_addr     = head_reg;
        rd_addr     = at_tail ? tail_reg : head_dec;
        if (accept)
        begin
            if (is_pop)
            begin
                if (count_reg != '0)
                begin
                    rd_en      = 1'b1;
                    valid_next = 1'b1;
                    count_next = count_reg - 1'b1;
                    if (at_tail)
                    begin
                        tail_next = tail_inc;
                    end
                    else
                    begin
                        head_next = head_dec;
                    end
                end
            end
            else
            begin
                if (count_reg == FULL_CNT)
                begin
                    reject_next = 1'b1;
                end
                else
                begin
                    wr_en      = 1'b1;
                    count_next = count_reg + 1'b1;
                    if (at_tail)
                    begin
                        wr_addr   = tail_dec;
                        tail_next = tail_dec;
                    end
                    else
                    begin
                        wr_addr   = head_reg;
                        head_next = head_inc;
                    end
                end
            end
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg   <= '0;
            tail_reg   <= '0;
            count_reg  <= '0;
            done_reg   <= 1'b0;
            valid_reg  <= 1'b0;
            reject_reg <= 1'b0;
        end
        else
        begin
            head_reg   <= head_next;
            tail_reg   <= tail_next;
            count_reg  <= count_next;
            done_reg   <= accept;
            valid_reg  <= valid_next;
            reject_reg <= reject_next;
        end
    end

    // task storage
    wsd_store #(
        .DEPTH (DEPTH),
        .WIDTH (wsd_pkg::HANDLE_WIDTH)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (req.task_handle),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // result beat
    assign count_ext = {{wsd_pkg::COUNT_WIDTH{1'b0}}, count_reg};
    assign done      = done_reg;

    always_comb
    begin
        rsp.popped_handle = valid_reg ? rd_data : '0;
        rsp.popped_valid  = valid_reg;
        rsp.push_rejected = reject_reg;
        rsp.queue_empty   = (count_reg == '0);
        rsp.entry_count   = count_ext[wsd_pkg::COUNT_WIDTH-1:0];
    end

endmodule

// File: rtl/wsd_store.sv
// wsd_store: task handle ring storage, one write and one read port
// read data is registered; depends on nothing but its parameters

module wsd_store #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 32
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule
